[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the retention check checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check that expr is never true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

[rtl/core/dfr_pkg.sv]
// ---------------------------------------------------------------------------
// dfr_pkg
// Types, constants and tables shared by the dated file retention check.
// ---------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

	// Register indexes of the configuration port
	localparam int unsigned REG_NOW_YEAR  = 0;
	localparam int unsigned REG_NOW_MONTH = 1;
	localparam int unsigned REG_NOW_DAY   = 2;
	localparam int unsigned REG_RETENTION = 3;

	// Register reset values
	localparam logic [13:0] RST_NOW_YEAR  = 14'd1970;
	localparam logic [3:0]  RST_NOW_MONTH = 4'd1;
	localparam logic [4:0]  RST_NOW_DAY   = 5'd1;
	localparam logic [15:0] RST_RETENTION = 16'd90;

	// ASCII digit bounds
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Calendar constants
	localparam logic [13:0] EPOCH_YEAR     = 14'd1970;
	localparam logic [13:0] LEAPS_TO_EPOCH = 14'd477;  // leap years in 1..1969
	localparam logic [12:0] DAYS_PER_YEAR  = 13'd365;
	localparam logic [3:0]  LAST_MONTH     = 4'd12;

	// x / 100 = (x * 5243) >> 19, exact for x below 16384
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int unsigned Q_LSB     = 19;
	localparam int unsigned Q_W       = 8;

	// Shared multiply-add unit widths
	localparam int unsigned MAC_A_W = 14;
	localparam int unsigned MAC_B_W = 13;
	localparam int unsigned MAC_C_W = 13;
	localparam int unsigned MAC_R_W = 28;

	typedef struct packed {
		logic [MAC_A_W-1:0] a;
		logic [MAC_B_W-1:0] b;
		logic [MAC_C_W-1:0] c;
	} mac_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QA,
		ST_QB,
		ST_SUM,
		ST_YR,
		ST_CAP,
		ST_OUT
	} state_t;

	// Days in the full months before month index fm (0 = January), common year
	function automatic logic [8:0] cum_days(input logic [3:0] fm);
		logic [8:0] d;
		unique case (fm)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/core/dfr_mac.sv]
// ---------------------------------------------------------------------------
// dfr_mac
// Shared multiply-add unit: res = a * b + c, registered, one op per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_mac import dfr_pkg::*; (
	input  wire logic               clk,
	input  wire mac_op_t            op,
	output logic [MAC_R_W-1:0]      res
);

	// Multiply, add and register
	always_ff @(posedge clk) begin
		res <= MAC_R_W'(op.a) * MAC_R_W'(op.b) + MAC_R_W'(op.c);
	end

endmodule

`default_nettype wire

[rtl/core/dated_file_retention_check.sv]
// ---------------------------------------------------------------------------
// dated_file_retention_check
// Checks an eight character YYYYMMDD name, counts its days since 1970-01-01
// and flags it expired against the configured current date and retention.
// ---------------------------------------------------------------------------
// One word in gives one word out. A name that is not a valid date (non-digit,
// month outside 1..12, day 0) goes from acceptance straight to the output
// state. A data file passes ST_QA, ST_QB, ST_SUM, ST_YR and ST_CAP once for
// the file date and once for the current date before the output state. This
// is set by the single multiply-add unit: each of the two dates (file and now)
// takes two reciprocal multiplies for the century terms and one multiply by
// 365 for the whole years, each followed by a register stage. Input is not
// taken while a word is in work; a finished result waits in the output
// register and the next word is accepted meanwhile. Configuration writes are
// taken in every cycle and should be made while no word is in work.
// ---------------------------------------------------------------------------
`default_nettype none

module dated_file_retention_check import dfr_pkg::*; #(
	parameter int unsigned CfgIdxW = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [15:0]        cfg_data,

	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         char_0,
	input  wire logic [7:0]         char_1,
	input  wire logic [7:0]         char_2,
	input  wire logic [7:0]         char_3,
	input  wire logic [7:0]         char_4,
	input  wire logic [7:0]         char_5,
	input  wire logic [7:0]         char_6,
	input  wire logic [7:0]         char_7,

	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    is_data_file,
	output logic                    expired,
	output logic [21:0]             file_day_count
);

	// Configuration registers
	logic [13:0] now_year_q;
	logic [3:0]  now_month_q;
	logic [4:0]  now_day_q;
	logic [15:0] ret_q;

	// Sequencer and datapath
	state_t             state_q, state_d;
	logic               ph_q;
	logic [13:0]        fyear_q;
	logic [3:0]         fmon_q;
	logic [6:0]         fdm1_q;
	logic [Q_W-1:0]     qa_q;
	logic [12:0]        c_q;
	logic [21:0]        file_d_q;
	logic               r_data_q, r_exp_q;
	logic [21:0]        r_days_q;
	logic               out_valid_q;
	logic               out_load;
	mac_op_t            mac_op;
	logic [MAC_R_W-1:0] mac_res;

	// Input decode
	logic [7:0]  chars [8];
	logic [3:0]  digs  [8];
	logic [7:0]  dig_ok;
	logic [13:0] in_year;
	logic [6:0]  in_month;
	logic [6:0]  in_day;
	logic        in_ok;
	logic        in_acc;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_year_q  <= RST_NOW_YEAR;
			now_month_q <= RST_NOW_MONTH;
			now_day_q   <= RST_NOW_DAY;
			ret_q       <= RST_RETENTION;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgIdxW'(REG_NOW_YEAR):  now_year_q  <= cfg_data[13:0];
				CfgIdxW'(REG_NOW_MONTH): now_month_q <= cfg_data[3:0];
				CfgIdxW'(REG_NOW_DAY):   now_day_q   <= cfg_data[4:0];
				CfgIdxW'(REG_RETENTION): ret_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Check the characters and form year, month and day
	assign chars = '{char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			dig_ok[i] = (chars[i] >= CH_ZERO) && (chars[i] <= CH_NINE);
			digs[i]   = chars[i][3:0];
		end
	end

	assign in_year  = {10'd0, digs[0]} * 14'd1000 + {10'd0, digs[1]} * 14'd100
	                + {10'd0, digs[2]} * 14'd10 + {10'd0, digs[3]};
	assign in_month = {3'd0, digs[4]} * 7'd10 + {3'd0, digs[5]};
	assign in_day   = {3'd0, digs[6]} * 7'd10 + {3'd0, digs[7]};
	assign in_ok    = (&dig_ok) && (in_month != 7'd0) && (in_month <= 7'(LAST_MONTH))
	                  && (in_day != 7'd0);
	assign in_acc   = in_valid && in_ready;

	// Select the date under work: file first, then now
	logic [3:0]  now_nm, now_fm, fm_sel;
	logic [6:0]  dm1_sel;
	logic [13:0] y_sel, y_m1, y_off;
	logic        y_gt;

	always_comb begin
		now_nm  = (now_month_q == 4'd0) ? 4'd1 : now_month_q;
		now_fm  = ((now_nm - 4'd1) > LAST_MONTH) ? LAST_MONTH : now_nm - 4'd1;
		y_sel   = ph_q ? now_year_q : fyear_q;
		fm_sel  = ph_q ? now_fm : fmon_q;
		dm1_sel = ph_q ? {2'd0, (now_day_q == 5'd0) ? 5'd0 : now_day_q - 5'd1} : fdm1_q;
		y_gt    = y_sel > EPOCH_YEAR;
		y_m1    = (y_sel == 14'd0) ? 14'd0 : y_sel - 14'd1;
		y_off   = y_gt ? y_sel - EPOCH_YEAR : 14'd0;
	end

	// Leap year and the addend for the year multiply
	logic [Q_W-1:0] qb;
	logic           cent, leap;
	logic [13:0]    ylp, c_sum;

	always_comb begin
		qb    = mac_res[Q_LSB +: Q_W];
		cent  = (y_sel == 14'd0) || (qa_q != qb);
		leap  = (y_sel[1:0] == 2'd0) && (!cent || (qa_q[1:0] == 2'd0));
		ylp   = y_gt ? ({2'd0, y_m1[13:2]} + {8'd0, qb[Q_W-1:2]} - {6'd0, qb}
		               - LEAPS_TO_EPOCH) : 14'd0;
		c_sum = {5'd0, cum_days(fm_sel)} + {13'd0, leap && (fm_sel >= 4'd2)}
		      + {7'd0, dm1_sel} + ylp;
	end

	// Expiry compare on the finished current-date count
	logic [22:0] exp_limit;
	logic        exp_now;

	assign exp_limit = {1'b0, file_d_q} + {7'd0, ret_q};
	assign exp_now   = mac_res[22:0] > exp_limit;

	dfr_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.res (mac_res)
	);

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, unit op and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		mac_op   = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = in_ok ? ST_QA : ST_OUT;
				end
			end
			ST_QA: begin
				mac_op.a = y_sel;
				mac_op.b = RECIP_100;
				state_d  = ST_QB;
			end
			ST_QB: begin
				mac_op.a = y_m1;
				mac_op.b = RECIP_100;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_YR;
			end
			ST_YR: begin
				mac_op.a = y_off;
				mac_op.b = DAYS_PER_YEAR;
				mac_op.c = c_q;
				state_d  = ST_CAP;
			end
			ST_CAP: begin
				state_d = ph_q ? ST_OUT : ST_QA;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Phase flag: advance to the current date after the file date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 1'b0;
		end else if (in_acc) begin
			ph_q <= 1'b0;
		end else if (state_q == ST_CAP) begin
			ph_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fyear_q  <= in_year;
			fmon_q   <= 4'(in_month - 7'd1);
			fdm1_q   <= in_day - 7'd1;
			r_data_q <= 1'b0;
			r_exp_q  <= 1'b0;
			r_days_q <= '0;
		end
		if (state_q == ST_QB) begin
			qa_q <= mac_res[Q_LSB +: Q_W];
		end
		if (state_q == ST_SUM) begin
			c_q <= c_sum[12:0];
		end
		if (state_q == ST_CAP) begin
			if (!ph_q) begin
				file_d_q <= mac_res[21:0];
			end else begin
				r_data_q <= 1'b1;
				r_exp_q  <= exp_now;
				r_days_q <= file_d_q;
			end
		end
	end

	// Output register: load the finished word, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_data_file   <= r_data_q;
			expired        <= r_exp_q;
			file_day_count <= r_days_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/dfr_checker.sv]
// ---------------------------------------------------------------------------
// dfr_checker
// Port-level checks for the dated file retention check, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        is_data_file,
	input wire logic        expired,
	input wire logic [21:0] file_day_count
);

	// Only a data file can be expired
	`ASSERT_NEVER(a_exp_needs_data, clk, arst_n, out_valid && expired && !is_data_file, "expired set on a word that is not a data file")

	// A rejected name reports a zero day count
	`ASSERT_PROP(a_reject_zero, clk, arst_n, out_valid && !is_data_file |-> file_day_count == 22'd0, "nonzero day count on a rejected name")

	// The block is busy in the cycle after taking a word
	`ASSERT_PROP(a_busy_after_in, clk, arst_n, in_valid && in_ready |=> !in_ready, "input ready right after a word was taken")

	// A stalled result holds
	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(file_day_count) && $stable(expired) && $stable(is_data_file), "stalled result changed")

endmodule

bind dated_file_retention_check dfr_checker u_dfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.is_data_file   (is_data_file),
	.expired        (expired),
	.file_day_count (file_day_count)
);

`default_nettype wire
